// ===== src/cfd_pkg.sv =====
// ---------------------------------------------------------------------------
// cfd_pkg
// Types, codes and constants of the charge field direction unit.
// ---------------------------------------------------------------------------
package cfd_pkg;

  localparam int COORD_W      = 11;
  localparam int Q_W          = 12;
  localparam int R2_W         = 23;   // dx^2 + dy^2 of 11-bit offsets
  localparam int ROOT_W       = 12;   // floor(sqrt(r2))
  localparam int DEN_W        = 35;   // r2 * root
  localparam int PROD_W       = 23;   // |q| * |d|
  localparam int SUM_BITS     = 56;   // saturation width of the field sums
  localparam int CORD_W       = 62;
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = 5;
  localparam int SQRT_IDX_W   = 4;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_EVAL  = 2'd2;

  localparam logic signed [SUM_BITS-1:0] SAT_MAX56 = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SAT_MIN56 = {1'b1, {(SUM_BITS-1){1'b0}}};
  localparam logic signed [CORD_W-1:0]   NORM_LIM  = 62'sh200_0000_0000_0000;
  localparam logic [31:0]                HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic        [1:0]         func;
    logic        [COORD_W-1:0] point_x;
    logic        [COORD_W-1:0] point_y;
    logic signed [Q_W-1:0]     charge;
  } req_item_t;

  typedef struct packed {
    logic signed [15:0] angle;
    logic               field_zero;
    logic               status;
  } rsp_item_t;

  typedef struct packed {
    logic        [COORD_W-1:0] x;
    logic        [COORD_W-1:0] y;
    logic signed [Q_W-1:0]     q;
  } entry_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== src/cfd_if.sv =====
// ---------------------------------------------------------------------------
// cfd_if
// Valid/ready channel carrying one item of type T.
// ---------------------------------------------------------------------------
interface cfd_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/charge_field_direction.sv =====
// ---------------------------------------------------------------------------
// charge_field_direction
// Point-charge table with Coulomb field direction lookup.
// ---------------------------------------------------------------------------
// req carries one item: clear the table, append a charge, or evaluate the
// field direction at a point. rsp returns exactly one item per request.
// Charges live in a synchronous table with one write port and one read port (one read per cycle).
// Requests are taken one at a time; ready is high only while idle.
// Clear and add go straight to the result. Evaluate walks the table one entry
// at a time: each stored charge is read, loaded, squared, put through a
// bit-serial square root, multiplied, divided by a restoring divide of NUM_W
// quotient bits for both components in parallel, and added with saturation;
// NUM_W = 23 + FRAC_BITS. A charge at the query point is skipped after its
// square is found. Then come normalising shifts and 30 CORDIC steps.
// The result sits in an output register; the next request is accepted while
// it waits, and the unit stalls only when a second result is ready before
// the first is taken. Reset empties the table (count to zero) and drops any
// pending result; table contents need no clearing.
// ---------------------------------------------------------------------------
module charge_field_direction
  import cfd_pkg::*;
#(
  parameter int MAX_CHARGES = 64,
  parameter int FRAC_BITS   = 24,
  parameter int ANGLE_BITS  = 16
) (
  input  logic   clk,
  input  logic   rst,
  cfd_if.sink    req,
  cfd_if.source  rsp
);

  localparam int AW    = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
  localparam int CNT_W = $clog2(MAX_CHARGES + 1);
  localparam int NUM_W = PROD_W + FRAC_BITS;
  localparam int SUM_W = ((NUM_W + 1 > SUM_BITS) ? NUM_W + 1 : SUM_BITS) + 1;
  localparam int DC_W  = $clog2(NUM_W);
  localparam logic [31:0] ROUND_ADD = 32'd1 << (31 - ANGLE_BITS);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(SAT_MAX56);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(SAT_MIN56);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_READ = 12'b0000_0000_0010,
    ST_LOAD = 12'b0000_0000_0100,
    ST_SQ   = 12'b0000_0000_1000,
    ST_SQRT = 12'b0000_0001_0000,
    ST_MUL  = 12'b0000_0010_0000,
    ST_DIV  = 12'b0000_0100_0000,
    ST_ACC  = 12'b0000_1000_0000,
    ST_FIN  = 12'b0001_0000_0000,
    ST_NORM = 12'b0010_0000_0000,
    ST_CORD = 12'b0100_0000_0000,
    ST_DONE = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // charge table
  entry_t mem [MAX_CHARGES];
  entry_t rd_data;
  logic   mem_we;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] k;

  logic [COORD_W-1:0] px, py;
  logic [COORD_W-1:0] adx, ady;
  logic               sx, sy, qneg;
  logic [Q_W-1:0]     qm;
  logic [R2_W-1:0]    r2;
  logic [ROOT_W-1:0]  root;
  logic [SQRT_IDX_W-1:0] sq_idx;
  logic [DEN_W-1:0]   den;
  logic [NUM_W-1:0]   nx, ny, qx, qy;
  logic [DEN_W-1:0]   rx, ry;
  logic [DC_W-1:0]    dcnt;

  logic signed [SUM_BITS-1:0] ex, ey;
  logic signed [CORD_W-1:0]   cx, cy;
  logic [31:0]                z;
  logic [STEP_W-1:0]          ci;

  rsp_item_t res;
  logic      out_valid;
  rsp_item_t out_data;

  logic req_acc;
  assign req_acc   = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign mem_we    = req_acc && (req.data.func == FUNC_ADD) &&
                     (count < CNT_W'(MAX_CHARGES));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[AW-1:0]] <= '{x: req.data.point_x, y: req.data.point_y,
                              q: req.data.charge};
    end
    rd_data <= mem[k[AW-1:0]];
  end

  // combinational helpers
  logic [COORD_W:0]   dxw, dyw;
  logic [R2_W-1:0]    r2_c;
  logic [ROOT_W-1:0]  cand;
  logic [2*ROOT_W-1:0] cand_sq;
  logic [DEN_W:0]     trial_x, trial_y;
  logic signed [SUM_W-1:0] tx, ty, sum_x, sum_y;
  logic signed [SUM_BITS-1:0] sat_x, sat_y;
  logic last_k;
  logic signed [CORD_W-1:0] ex_w, ey_w, xs, ys;
  logic cx_small, cy_small;
  logic [31:0] z_step, z_round, ang_full;

  always_comb begin
    dxw     = {1'b0, px} - {1'b0, rd_data.x};
    dyw     = {1'b0, py} - {1'b0, rd_data.y};
    r2_c    = R2_W'(adx) * R2_W'(adx) + R2_W'(ady) * R2_W'(ady);
    cand    = root | (ROOT_W'(1) << sq_idx);
    cand_sq = cand * cand;
    trial_x = {rx, nx[NUM_W-1]};
    trial_y = {ry, ny[NUM_W-1]};
    tx      = SUM_W'(qx);
    ty      = SUM_W'(qy);
    if (qneg ^ sx) tx = -tx;
    if (qneg ^ sy) ty = -ty;
    sum_x   = SUM_W'(ex) + tx;
    sum_y   = SUM_W'(ey) + ty;
    sat_x   = (sum_x > SAT_HI) ? SAT_MAX56 :
              (sum_x < SAT_LO) ? SAT_MIN56 : sum_x[SUM_BITS-1:0];
    sat_y   = (sum_y > SAT_HI) ? SAT_MAX56 :
              (sum_y < SAT_LO) ? SAT_MIN56 : sum_y[SUM_BITS-1:0];
    last_k  = ((k + 1'b1) == count);
    ex_w    = CORD_W'(ex);
    ey_w    = CORD_W'(ey);
    xs      = cx >>> ci;
    ys      = cy >>> ci;
    cx_small = (cx < NORM_LIM) && (cx > -NORM_LIM);
    cy_small = (cy < NORM_LIM) && (cy > -NORM_LIM);
    z_step  = (cy >= 0) ? z + atan_turn(ci) : z - atan_turn(ci);
    z_round = z_step + ROUND_ADD;
    ang_full = z_round >> (32 - ANGLE_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      k     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_acc) begin
            px  <= req.data.point_x;
            py  <= req.data.point_y;
            res <= '{angle: '0, field_zero: 1'b0,
                     status: (req.data.func == FUNC_ADD) &&
                             (count >= CNT_W'(MAX_CHARGES))};
            ex  <= '0;
            ey  <= '0;
            k   <= '0;
            state <= ST_DONE;
            unique case (req.data.func)
              FUNC_CLEAR: count <= '0;
              FUNC_ADD: begin
                if (count < CNT_W'(MAX_CHARGES)) count <= count + 1'b1;
              end
              FUNC_EVAL: state <= (count == '0) ? ST_FIN : ST_READ;
              default: ;
            endcase
          end
        end
        ST_READ: state <= ST_LOAD;
        ST_LOAD: begin
          adx  <= dxw[COORD_W] ? COORD_W'(-dxw) : dxw[COORD_W-1:0];
          ady  <= dyw[COORD_W] ? COORD_W'(-dyw) : dyw[COORD_W-1:0];
          sx   <= dxw[COORD_W];
          sy   <= dyw[COORD_W];
          qneg <= rd_data.q[Q_W-1];
          qm   <= rd_data.q[Q_W-1] ? Q_W'(-rd_data.q) : Q_W'(rd_data.q);
          state <= ST_SQ;
        end
        ST_SQ: begin
          r2     <= r2_c;
          root   <= '0;
          sq_idx <= SQRT_IDX_W'(ROOT_W - 1);
          if (r2_c == '0) begin
            // charge at the query point: skipped
            k     <= k + 1'b1;
            state <= last_k ? ST_FIN : ST_READ;
          end else begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (cand_sq <= (2*ROOT_W)'(r2)) root <= cand;
          sq_idx <= sq_idx - 1'b1;
          if (sq_idx == '0) state <= ST_MUL;
        end
        ST_MUL: begin
          den  <= DEN_W'(r2) * DEN_W'(root);
          nx   <= NUM_W'(PROD_W'(qm) * PROD_W'(adx)) << FRAC_BITS;
          ny   <= NUM_W'(PROD_W'(qm) * PROD_W'(ady)) << FRAC_BITS;
          rx   <= '0;
          ry   <= '0;
          dcnt <= DC_W'(NUM_W - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle for each component
          if (trial_x >= {1'b0, den}) begin
            rx <= DEN_W'(trial_x - {1'b0, den});
            qx <= {qx[NUM_W-2:0], 1'b1};
          end else begin
            rx <= trial_x[DEN_W-1:0];
            qx <= {qx[NUM_W-2:0], 1'b0};
          end
          if (trial_y >= {1'b0, den}) begin
            ry <= DEN_W'(trial_y - {1'b0, den});
            qy <= {qy[NUM_W-2:0], 1'b1};
          end else begin
            ry <= trial_y[DEN_W-1:0];
            qy <= {qy[NUM_W-2:0], 1'b0};
          end
          nx   <= nx << 1;
          ny   <= ny << 1;
          dcnt <= dcnt - 1'b1;
          if (dcnt == '0) state <= ST_ACC;
        end
        ST_ACC: begin
          ex    <= sat_x;
          ey    <= sat_y;
          k     <= k + 1'b1;
          state <= last_k ? ST_FIN : ST_READ;
        end
        ST_FIN: begin
          if (ex == '0 && ey == '0) begin
            res.field_zero <= 1'b1;
            state <= ST_DONE;
          end else begin
            // fold into the right half plane first
            cx <= ex[SUM_BITS-1] ? -ex_w : ex_w;
            cy <= ex[SUM_BITS-1] ? -ey_w : ey_w;
            z  <= ex[SUM_BITS-1] ? HALF_TURN : 32'd0;
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          ci <= '0;
          if (cx_small && cy_small) begin
            cx <= cx <<< 1;
            cy <= cy <<< 1;
          end else begin
            state <= ST_CORD;
          end
        end
        ST_CORD: begin
          if (cy >= 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
          end
          z  <= z_step;
          ci <= ci + 1'b1;
          if (ci == STEP_W'(CORDIC_STEPS - 1)) begin
            res.angle <= ang_full[15:0];
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || rsp.ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || rsp.ready)) out_data <= res;
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_CHARGES))
    else $error("charge count beyond table size");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rx < den) && (ry < den))
    else $error("divider remainder not below divisor");

  a_add_count: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.data.func == FUNC_ADD && count < CNT_W'(MAX_CHARGES))
    |=> (count == $past(count) + 1'b1))
    else $error("add did not advance the charge count");

  a_cord_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CORD) |-> (ci < STEP_W'(CORDIC_STEPS)))
    else $error("CORDIC step counter overran");

endmodule
